[rtl/spims_pkg.sv]
package spims_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;
   localparam logic [2:0] TOP_BIT = 3'd7;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_SHIFT = 2'd1,
      PH_GAP   = 2'd2
   } phase_type;

   typedef struct packed {
      logic send;
      logic capture;
      logic final_slot;
   } slot_flags_type;

   typedef struct packed {
      logic           miso_level;
      logic           slot_valid;
      logic [7:0]     tx_byte;
      slot_flags_type flags;
   } tick_type;

   typedef struct packed {
      logic       chip_select_n;
      logic       serial_clock;
      logic       mosi_level;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       slot_taken;
      logic       busy_res;
   } line_type;

endpackage

[rtl/spi_master_byte_shifter_core.sv]
// SPI master, mode 0, MSB first, advanced one tick per input item. Every accepted
// item is one tick of the serial line and yields exactly one result item carrying
// the line levels (chip select, SCK, MOSI) for that tick, plus a received byte when
// a captured byte completes, a slot-taken flag and a busy flag. A slot offered in
// idle or between slots starts a byte at once (that tick is the low phase of bit 7);
// a slot offered while a byte is shifting is dropped with slot_taken low. Each bit
// spends two ticks: low phase drives MOSI and samples MISO, high phase raises SCK.
// SCK stays high between slots and returns low with chip select high after the
// slot marked final. Throughput is one item per clock while rsp_ready does not
// hold the output back: a small input queue feeds the tick engine, whose state
// update for one tick is combinational; each item goes from a queue entry to a
// registered output stage, which holds a result while the queue takes new items.
module spi_master_byte_shifter_core #(
   parameter int QUEUE_DEPTH = spims_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_miso_level,
   input  logic       req_slot_valid,
   input  logic [7:0] req_tx_byte,
   input  logic       req_send_enable,
   input  logic       req_capture_enable,
   input  logic       req_final_slot,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_chip_select_n,
   output logic       rsp_serial_clock,
   output logic       rsp_mosi_level,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_rx_valid,
   output logic       rsp_slot_taken,
   output logic       rsp_busy_res
);

   logic                q_valid;
   logic                q_pop;
   spims_pkg::tick_type q_item;
   spims_pkg::line_type rsp_line;

   // front: accept ticks and queue them with their slot flags packed
   spims_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_miso_level     (req_miso_level),
      .req_slot_valid     (req_slot_valid),
      .req_tx_byte        (req_tx_byte),
      .req_send_enable    (req_send_enable),
      .req_capture_enable (req_capture_enable),
      .req_final_slot     (req_final_slot),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   // back: run the shifter one tick per queued item into the output register
   spims_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_line  (rsp_line)
   );

   // unpack the result item onto its ports
   assign rsp_chip_select_n = rsp_line.chip_select_n;
   assign rsp_serial_clock  = rsp_line.serial_clock;
   assign rsp_mosi_level    = rsp_line.mosi_level;
   assign rsp_rx_byte       = rsp_line.rx_byte;
   assign rsp_rx_valid      = rsp_line.rx_valid;
   assign rsp_slot_taken    = rsp_line.slot_taken;
   assign rsp_busy_res      = rsp_line.busy_res;

endmodule

[rtl/spims_front.sv]
module spims_front #(
   parameter int QUEUE_DEPTH = spims_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_miso_level,
   input  logic                req_slot_valid,
   input  logic [7:0]          req_tx_byte,
   input  logic                req_send_enable,
   input  logic                req_capture_enable,
   input  logic                req_final_slot,
   output logic                q_valid,
   output spims_pkg::tick_type q_item,
   input  logic                q_pop
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

   spims_pkg::tick_type entry_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   spims_pkg::tick_type item_new;
   logic push;

   // classify the incoming tick: pack the slot flags together
   always_comb begin
      item_new.miso_level       = req_miso_level;
      item_new.slot_valid       = req_slot_valid;
      item_new.tx_byte          = req_tx_byte;
      item_new.flags.send       = req_send_enable;
      item_new.flags.capture    = req_capture_enable;
      item_new.flags.final_slot = req_final_slot;
   end

   assign req_ready = (count_ff != FULL_COUNT);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

[rtl/spims_engine.sv]
module spims_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  spims_pkg::tick_type q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output spims_pkg::line_type rsp_line
);

   spims_pkg::phase_type      phase_ff, phase_in, phase_eff;
   logic [2:0]                bit_ff, bit_in, bit_eff;
   logic                      half_ff, half_in, half_eff;
   logic [7:0]                tx_ff, tx_in, tx_eff;
   logic [7:0]                rx_ff, rx_in, rx_eff;
   spims_pkg::slot_flags_type flags_ff, flags_in, flags_eff;
   logic                      mosi_ff, mosi_in;
   spims_pkg::line_type       line_ff, line_in;
   logic                      out_valid_ff, out_valid_in;
   logic                      advance, taken;

   // advance one tick whenever the output register is free or being drained
   assign advance = q_valid && (!out_valid_ff || rsp_ready);
   assign q_pop   = advance;

   // a slot is taken outside shifting; the taking tick is bit 7 low phase
   assign taken     = (phase_ff != spims_pkg::PH_SHIFT) && q_item.slot_valid;
   assign phase_eff = taken ? spims_pkg::PH_SHIFT : phase_ff;
   assign bit_eff   = taken ? spims_pkg::TOP_BIT : bit_ff;
   assign half_eff  = taken ? 1'b0 : half_ff;
   assign tx_eff    = taken ? q_item.tx_byte : tx_ff;
   assign rx_eff    = taken ? 8'd0 : rx_ff;
   assign flags_eff = taken ? q_item.flags : flags_ff;

   always_comb begin
      phase_in = phase_eff;
      case (phase_eff)
         spims_pkg::PH_SHIFT: begin
            if (half_eff && (bit_eff == 3'd0)) begin
               phase_in = flags_eff.final_slot ? spims_pkg::PH_IDLE : spims_pkg::PH_GAP;
            end
         end
         spims_pkg::PH_GAP: phase_in = spims_pkg::PH_GAP;
         default:           phase_in = spims_pkg::PH_IDLE;
      endcase
   end

   always_comb begin
      bit_in   = bit_eff;
      half_in  = half_eff;
      tx_in    = tx_eff;
      rx_in    = rx_eff;
      flags_in = flags_eff;
      mosi_in  = mosi_ff;
      line_in  = '0;
      line_in.chip_select_n = 1'b1;
      line_in.slot_taken    = taken;
      case (phase_eff)
         spims_pkg::PH_SHIFT: begin
            line_in.busy_res      = 1'b1;
            line_in.chip_select_n = 1'b0;
            if (!half_eff) begin
               if (flags_eff.send) begin
                  mosi_in = tx_eff[bit_eff];
               end
               if (flags_eff.capture) begin
                  rx_in[bit_eff] = rx_eff[bit_eff] | q_item.miso_level;
               end
               half_in = 1'b1;
            end else begin
               line_in.serial_clock = 1'b1;
               half_in = 1'b0;
               if (bit_eff == 3'd0) begin
                  if (flags_eff.capture) begin
                     line_in.rx_valid = 1'b1;
                     line_in.rx_byte  = rx_eff;
                  end
                  bit_in = spims_pkg::TOP_BIT;
               end else begin
                  bit_in = bit_eff - 3'd1;
               end
            end
         end
         spims_pkg::PH_GAP: begin
            line_in.busy_res      = 1'b1;
            line_in.chip_select_n = 1'b0;
            line_in.serial_clock  = 1'b1;
         end
         default: begin
            line_in.serial_clock = 1'b0;
         end
      endcase
      line_in.mosi_level = mosi_in;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= spims_pkg::PH_IDLE;
         bit_ff       <= spims_pkg::TOP_BIT;
         half_ff      <= 1'b0;
         tx_ff        <= '0;
         rx_ff        <= '0;
         flags_ff     <= '0;
         mosi_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            bit_ff   <= bit_in;
            half_ff  <= half_in;
            tx_ff    <= tx_in;
            rx_ff    <= rx_in;
            flags_ff <= flags_in;
            mosi_ff  <= mosi_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         line_ff <= line_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_line  = line_ff;

endmodule
